/* sv/vfld_pkg.sv */
// Shared types and constants for the vertex format layout decoder.
`timescale 1ns / 1ps

package vfld_pkg;

  localparam int MaxTexSetsDefault = 8;
  localparam int QueueDepth        = 2;

  // Semantic codes
  localparam logic [2:0] SEM_POSITION = 3'd0;
  localparam logic [2:0] SEM_NORMAL   = 3'd1;
  localparam logic [2:0] SEM_PSIZE    = 3'd2;
  localparam logic [2:0] SEM_COLOR    = 3'd3;
  localparam logic [2:0] SEM_TEXCOORD = 3'd4;

  // Element format codes
  localparam logic [2:0] FMT_FLOAT1 = 3'd0;
  localparam logic [2:0] FMT_FLOAT2 = 3'd1;
  localparam logic [2:0] FMT_FLOAT3 = 3'd2;
  localparam logic [2:0] FMT_FLOAT4 = 3'd3;
  localparam logic [2:0] FMT_BGRA   = 3'd4;

  // Color indexes
  localparam logic [2:0] IDX_DIFFUSE  = 3'd0;
  localparam logic [2:0] IDX_SPECULAR = 3'd1;

  // Position kind codes on bits 3..1 (bit 14 must be clear)
  localparam logic [2:0] POS_KIND_XYZ    = 3'b001;
  localparam logic [2:0] POS_KIND_XYZRHW = 3'b010;

  // Classified format word, passed from front to back
  typedef struct packed {
    logic        ok;
    logic        rhw;
    logic        normal;
    logic        psize;
    logic        diffuse;
    logic        specular;
    logic [3:0]  sets;
    logic [15:0] size_codes;
  } vfld_item_t;

  // Size code to float-format code: 0 two, 1 three, 2 four, 3 one float
  function automatic logic [2:0] tex_fmt(input logic [1:0] code);
    logic [2:0] fmt;
    unique case (code)
      2'd0:    fmt = FMT_FLOAT2;
      2'd1:    fmt = FMT_FLOAT3;
      2'd2:    fmt = FMT_FLOAT4;
      default: fmt = FMT_FLOAT1;
    endcase
    return fmt;
  endfunction

endpackage

/* sv/vfld_front.sv */
// Front end: accepts format words and classifies them into queue entries.
`timescale 1ns / 1ps

module vfld_front import vfld_pkg::*; #(
  parameter int MAX_TEX_SETS = MaxTexSetsDefault
) (
  input  logic        in_push,
  input  logic [31:0] in_format_word,
  input  logic        q_full,
  output logic        q_wr,
  output vfld_item_t  q_wr_data
);

  logic pos_xyz;
  logic pos_rhw;
  logic sets_ok;

  always_comb begin
    pos_xyz = !in_format_word[14] && (in_format_word[3:1] == POS_KIND_XYZ);
    pos_rhw = !in_format_word[14] && (in_format_word[3:1] == POS_KIND_XYZRHW);
    sets_ok = in_format_word[11:8] <= 4'(MAX_TEX_SETS);

    q_wr                 = in_push && !q_full;
    q_wr_data.ok         = (pos_xyz || pos_rhw) && sets_ok;
    q_wr_data.rhw        = pos_rhw;
    q_wr_data.normal     = in_format_word[4];
    q_wr_data.psize      = in_format_word[5];
    q_wr_data.diffuse    = in_format_word[6];
    q_wr_data.specular   = in_format_word[7];
    q_wr_data.sets       = in_format_word[11:8];
    q_wr_data.size_codes = in_format_word[31:16];
  end

endmodule

/* sv/vfld_fifo.sv */
// Short queue of classified words between front and back.
`timescale 1ns / 1ps

module vfld_fifo import vfld_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr,
  input  vfld_item_t wr_data,
  input  logic       rd,
  output vfld_item_t rd_data,
  output logic       full,
  output logic       empty
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  vfld_item_t          mem [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_r;
  logic [PtrW-1:0]     rd_ptr_r;
  logic [CntW-1:0]     count_r;

  assign full    = (count_r == CntW'(QueueDepth));
  assign empty   = (count_r == '0);
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr && !rd) begin
        count_r <= count_r + 1'b1;
      end else if (rd && !wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* sv/vfld_back.sv */
// Back end: walks one classified word and emits its descriptors in order.
`timescale 1ns / 1ps

module vfld_back import vfld_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  vfld_item_t q_rd_data,
  input  logic       q_empty,
  output logic       q_rd,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_ok,
  output logic [2:0] out_semantic,
  output logic [2:0] out_attr_index,
  output logic [2:0] out_element_format,
  output logic [7:0] out_byte_offset,
  output logic [3:0] out_element_number,
  output logic       out_last,
  output logic [7:0] out_stride
);

  typedef enum logic [2:0] {
    PH_POS, PH_NORM, PH_PSIZE, PH_DIFF, PH_SPEC, PH_TEX, PH_REJ, PH_IDLE
  } phase_t;

  phase_t     phase_r, phase_nxt;
  vfld_item_t item_r;
  logic [7:0] off_r;
  logic [3:0] num_r;
  logic [2:0] tex_r;
  logic       out_valid_r;

  logic [2:0] sem, idx, fmt;
  logic [4:0] size;
  logic       last_c;
  logic       word_pop;
  logic       emit;

  assign word_pop  = out_pop && out_valid_r;
  assign q_rd      = (phase_r == PH_IDLE) && !q_empty;
  assign emit      = (phase_r != PH_IDLE) && (!out_valid_r || word_pop);
  assign out_empty = !out_valid_r;

  always_comb begin
    sem  = '0;
    idx  = '0;
    fmt  = '0;
    size = '0;
    unique case (phase_r)
      PH_POS: begin
        sem  = SEM_POSITION;
        fmt  = item_r.rhw ? FMT_FLOAT4 : FMT_FLOAT3;
        size = item_r.rhw ? 5'd16 : 5'd12;
      end
      PH_NORM: begin
        sem  = SEM_NORMAL;
        fmt  = FMT_FLOAT3;
        size = 5'd12;
      end
      PH_PSIZE: begin
        sem  = SEM_PSIZE;
        fmt  = FMT_FLOAT1;
        size = 5'd4;
      end
      PH_DIFF: begin
        sem  = SEM_COLOR;
        idx  = IDX_DIFFUSE;
        fmt  = FMT_BGRA;
        size = 5'd4;
      end
      PH_SPEC: begin
        sem  = SEM_COLOR;
        idx  = IDX_SPECULAR;
        fmt  = FMT_BGRA;
        size = 5'd4;
      end
      PH_TEX: begin
        sem  = SEM_TEXCOORD;
        idx  = tex_r;
        fmt  = tex_fmt(item_r.size_codes[{tex_r, 1'b0} +: 2]);
        size = {fmt[1:0] + 2'd1, 2'b00} == 4'd0 ? 5'd16 : {1'b0, fmt[1:0] + 2'd1, 2'b00};
      end
      default: begin
      end
    endcase

    // Pick the next attribute that is present, in list order
    priority if (phase_r == PH_REJ || phase_r == PH_IDLE) begin
      phase_nxt = PH_IDLE;
    end else if (phase_r == PH_TEX && ({1'b0, tex_r} + 4'd1) < item_r.sets) begin
      phase_nxt = PH_TEX;
    end else if (phase_r < PH_NORM && item_r.normal) begin
      phase_nxt = PH_NORM;
    end else if (phase_r < PH_PSIZE && item_r.psize) begin
      phase_nxt = PH_PSIZE;
    end else if (phase_r < PH_DIFF && item_r.diffuse) begin
      phase_nxt = PH_DIFF;
    end else if (phase_r < PH_SPEC && item_r.specular) begin
      phase_nxt = PH_SPEC;
    end else if (phase_r < PH_TEX && item_r.sets != 4'd0) begin
      phase_nxt = PH_TEX;
    end else begin
      phase_nxt = PH_IDLE;
    end
    last_c = (phase_nxt == PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (word_pop) begin
        out_valid_r <= 1'b0;
      end
      if (q_rd) begin
        item_r  <= q_rd_data;
        phase_r <= q_rd_data.ok ? PH_POS : PH_REJ;
        off_r   <= '0;
        num_r   <= '0;
        tex_r   <= '0;
      end else if (emit) begin
        out_ok             <= (phase_r != PH_REJ);
        out_semantic       <= sem;
        out_attr_index     <= idx;
        out_element_format <= fmt;
        out_byte_offset    <= off_r;
        out_element_number <= num_r;
        out_last           <= last_c;
        out_stride         <= last_c ? off_r + {3'b000, size} : 8'd0;
        phase_r            <= phase_nxt;
        off_r              <= off_r + {3'b000, size};
        num_r              <= num_r + 4'd1;
        tex_r              <= (phase_r == PH_TEX) ? tex_r + 3'd1 : 3'd0;
      end
    end
  end

endmodule

/* sv/vertex_format_layout_decoder.sv */
// Vertex format layout decoder: queue-style front, classification, descriptor sequencer.
// An accepted word waits in the two-entry queue until the idle sequencer loads it; then
// its first descriptor is registered. One descriptor per cycle while the receiver pops;
// a word with n descriptors (1 to 13) is done before the sequencer loads the next word.
// Reset: synchronous, active low; empties the queue and the result register.
`timescale 1ns / 1ps

module vertex_format_layout_decoder import vfld_pkg::*; #(
  parameter int MAX_TEX_SETS = MaxTexSetsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_format_word,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_ok,
  output logic [2:0]  out_semantic,
  output logic [2:0]  out_attr_index,
  output logic [2:0]  out_element_format,
  output logic [7:0]  out_byte_offset,
  output logic [3:0]  out_element_number,
  output logic        out_last,
  output logic [7:0]  out_stride
);

  vfld_item_t q_wr_data;
  vfld_item_t q_rd_data;
  logic       q_wr;
  logic       q_rd;
  logic       q_empty;

  vfld_front #(
    .MAX_TEX_SETS(MAX_TEX_SETS)
  ) u_front (
    .in_push       (in_push),
    .in_format_word(in_format_word),
    .q_full        (in_full),
    .q_wr          (q_wr),
    .q_wr_data     (q_wr_data)
  );

  vfld_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (q_wr),
    .wr_data(q_wr_data),
    .rd     (q_rd),
    .rd_data(q_rd_data),
    .full   (in_full),
    .empty  (q_empty)
  );

  vfld_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_rd_data         (q_rd_data),
    .q_empty           (q_empty),
    .q_rd              (q_rd),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_ok            (out_ok),
    .out_semantic      (out_semantic),
    .out_attr_index    (out_attr_index),
    .out_element_format(out_element_format),
    .out_byte_offset   (out_byte_offset),
    .out_element_number(out_element_number),
    .out_last          (out_last),
    .out_stride        (out_stride)
  );

  // A rejected word is a single terminal word with no stride
  a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_ok) |-> (out_last && out_stride == 8'd0 &&
                                 out_element_number == 4'd0))
    else $error("rejected word not a lone terminal word");

  // Every accepted list opens with the position at offset zero
  a_first_is_position: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_ok && out_element_number == 4'd0) |->
      (out_semantic == SEM_POSITION && out_byte_offset == 8'd0))
    else $error("descriptor list does not open with position");

  // Stride shows up only on the final descriptor
  a_stride_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_last) |-> (out_stride == 8'd0))
    else $error("stride on a non-final descriptor");

  // After a popped non-final descriptor the list continues from the same word
  a_list_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_last) |=>
      (out_empty || out_element_number == $past(out_element_number) + 4'd1))
    else $error("descriptor numbering broke inside a word");

endmodule

/* test/vertex_format_layout_decoder_test.sv */
// Self-checking testbench for the vertex format layout decoder: queue driver, monitor, predictor.
`timescale 1ns / 1ps

module vertex_format_layout_decoder_test;
  import vfld_pkg::*;

  localparam int          MaxSets      = MaxTexSetsDefault;
  localparam logic [31:0] PosMask      = 32'h0000_400E;
  localparam logic [31:0] PosXyz       = {28'd0, POS_KIND_XYZ, 1'b0};
  localparam logic [31:0] PosXyzrhw    = {28'd0, POS_KIND_XYZRHW, 1'b0};
  localparam logic [31:0] PosBit14     = 32'h0000_4000;
  localparam logic [31:0] HasNormal    = 32'h0000_0010;
  localparam logic [31:0] HasPsize     = 32'h0000_0020;
  localparam logic [31:0] HasDiffuse   = 32'h0000_0040;
  localparam logic [31:0] HasSpecular  = 32'h0000_0080;
  localparam logic [31:0] AllFlags     = 32'h0000_00F0;
  localparam logic [31:0] SetCountMask = 32'h0000_0F00;
  localparam int          TimeoutNs    = 2_000_000;

  typedef struct packed {
    logic       ok;
    logic [2:0] semantic;
    logic [2:0] attr_index;
    logic [2:0] element_format;
    logic [7:0] byte_offset;
    logic [3:0] element_number;
    logic       last;
    logic [7:0] stride;
  } layout_desc_t;

  typedef struct {
    logic [31:0] word;
    bit          drain;  // hold until every expected descriptor has come
    bit          rush;   // no idling on either side
  } word_req_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [31:0] in_format_word = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic        out_ok;
  logic [2:0]  out_semantic;
  logic [2:0]  out_attr_index;
  logic [2:0]  out_element_format;
  logic [7:0]  out_byte_offset;
  logic [3:0]  out_element_number;
  logic        out_last;
  logic [7:0]  out_stride;

  layout_desc_t layout_due[$];
  word_req_t    word_backlog[$];
  layout_desc_t got_desc;
  layout_desc_t want_desc;
  int           errors = 0;
  logic         word_taken = 1'b0;
  logic         rush_mode = 1'b0;
  int unsigned  send_gap = 0;
  int unsigned  pop_stall = 0;

  vertex_format_layout_decoder dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_format_word     (in_format_word),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_ok             (out_ok),
    .out_semantic       (out_semantic),
    .out_attr_index     (out_attr_index),
    .out_element_format (out_element_format),
    .out_byte_offset    (out_byte_offset),
    .out_element_number (out_element_number),
    .out_last           (out_last),
    .out_stride         (out_stride)
  );

  function automatic layout_desc_t make_desc(input logic [2:0] sem, input logic [2:0] idx,
                                             input logic [2:0] fmt, input int unsigned off,
                                             input int unsigned n);
    layout_desc_t d;
    d = '0;
    d.ok             = 1'b1;
    d.semantic       = sem;
    d.attr_index     = idx;
    d.element_format = fmt;
    d.byte_offset    = off[7:0];
    d.element_number = n[3:0];
    return d;
  endfunction

  // Queue the descriptor list that one format word yields.
  function automatic void decode_layout(input logic [31:0] w);
    layout_desc_t d;
    layout_desc_t list[$];
    logic [31:0]  pos;
    int unsigned  sets;
    int unsigned  off;
    int unsigned  floats;
    logic [2:0]   fmt;
    logic [1:0]   code;
    pos  = w & PosMask;
    sets = 32'(w[11:8]);
    if ((pos != PosXyz && pos != PosXyzrhw) || sets > MaxSets) begin
      d = '0;
      d.last = 1'b1;
      layout_due.push_back(d);
      return;
    end
    if (pos == PosXyz) begin
      list.push_back(make_desc(SEM_POSITION, 3'd0, FMT_FLOAT3, 0, 0));
      off = 12;
    end else begin
      list.push_back(make_desc(SEM_POSITION, 3'd0, FMT_FLOAT4, 0, 0));
      off = 16;
    end
    if ((w & HasNormal) != 0) begin
      list.push_back(make_desc(SEM_NORMAL, 3'd0, FMT_FLOAT3, off, list.size()));
      off += 12;
    end
    if ((w & HasPsize) != 0) begin
      list.push_back(make_desc(SEM_PSIZE, 3'd0, FMT_FLOAT1, off, list.size()));
      off += 4;
    end
    if ((w & HasDiffuse) != 0) begin
      list.push_back(make_desc(SEM_COLOR, IDX_DIFFUSE, FMT_BGRA, off, list.size()));
      off += 4;
    end
    if ((w & HasSpecular) != 0) begin
      list.push_back(make_desc(SEM_COLOR, IDX_SPECULAR, FMT_BGRA, off, list.size()));
      off += 4;
    end
    for (int s = 0; s < sets; s++) begin
      code = w[16 + 2 * s +: 2];
      case (code)
        2'd0:    begin fmt = FMT_FLOAT2; floats = 2; end
        2'd1:    begin fmt = FMT_FLOAT3; floats = 3; end
        2'd2:    begin fmt = FMT_FLOAT4; floats = 4; end
        default: begin fmt = FMT_FLOAT1; floats = 1; end
      endcase
      list.push_back(make_desc(SEM_TEXCOORD, s[2:0], fmt, off, list.size()));
      off += floats * 4;
    end
    d = list.pop_back();
    d.last   = 1'b1;
    d.stride = off[7:0];
    list.push_back(d);
    foreach (list[i]) layout_due.push_back(list[i]);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want_v,
                                      input logic [7:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Monitor: check the popped word, then predict for the pushed one.
  always @(posedge clk) begin
    word_taken <= rst_n && in_push && !in_full;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        got_desc = '{out_ok, out_semantic, out_attr_index, out_element_format,
                     out_byte_offset, out_element_number, out_last, out_stride};
        if (layout_due.size() == 0) begin
          $error("descriptor word with nothing expected: ok %0d semantic %0d",
                 out_ok, out_semantic);
          errors++;
        end else begin
          want_desc = layout_due.pop_front();
          check_field("ok", 8'(want_desc.ok), 8'(got_desc.ok));
          check_field("semantic", 8'(want_desc.semantic), 8'(got_desc.semantic));
          check_field("attr_index", 8'(want_desc.attr_index),
                      8'(got_desc.attr_index));
          check_field("element_format", 8'(want_desc.element_format),
                      8'(got_desc.element_format));
          check_field("byte_offset", want_desc.byte_offset, got_desc.byte_offset);
          check_field("element_number", 8'(want_desc.element_number),
                      8'(got_desc.element_number));
          check_field("last", 8'(want_desc.last), 8'(got_desc.last));
          check_field("stride", want_desc.stride, got_desc.stride);
        end
      end
      if (in_push && !in_full) decode_layout(in_format_word);
    end
  end

  // Driver: feed format words from the backlog.
  always @(negedge clk) begin
    logic push_next;
    push_next = 1'b0;
    if (rst_n) begin
      if (word_taken) begin
        word_backlog.delete(0);
        if (word_backlog.size() > 0 && !word_backlog[0].rush) send_gap = pick_gap();
        else send_gap = 0;
      end
      if (send_gap > 0) begin
        send_gap--;
      end else if (word_backlog.size() > 0 &&
                   !(word_backlog[0].drain && layout_due.size() != 0)) begin
        push_next = 1'b1;
        in_format_word <= word_backlog[0].word;
      end
      rush_mode <= word_backlog.size() > 0 && word_backlog[0].rush;
    end
    in_push <= push_next;
  end

  // Receiver: pop with random stalls.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (rush_mode) begin
      out_pop <= 1'b1;
    end else if (pop_stall > 0) begin
      out_pop <= 1'b0;
      pop_stall--;
    end else if ($urandom_range(0, 7) == 0) begin
      out_pop <= 1'b0;
      pop_stall = pick_gap();
    end else begin
      out_pop <= 1'b1;
    end
  end

  initial begin
    logic [31:0] directed[$];
    word_req_t   req;
    logic [31:0] w;
    int unsigned r;
    directed = '{
      PosXyz,
      PosXyzrhw,
      PosXyzrhw | AllFlags | (32'd8 << 8) | 32'hAAAA_0000,  // longest list, widest stride
      PosXyz | AllFlags | (32'd8 << 8) | 32'hFFFF_0000,
      PosXyz | (32'd4 << 8) | 32'h00E4_0000,                 // every size code once
      PosXyz | HasNormal,
      PosXyz | HasPsize,
      PosXyz | HasDiffuse,
      PosXyz | HasSpecular,
      PosXyz | (32'd9 << 8),                                 // one set too many
      PosXyzrhw | SetCountMask,
      32'h0000_0000,                                         // no position
      32'h0000_0006,
      32'h0000_000E,
      32'h0000_0008,
      PosXyz | PosBit14,
      32'hFFFF_FFFF,
      PosXyz | 32'hFFFF_B001,                                // ignored bits set
      PosXyzrhw | (32'd1 << 8) | 32'h0003_0000,
      PosXyzrhw | AllFlags,
      PosXyz | HasDiffuse | (32'd8 << 8) | 32'h1B6C_0000
    };
    foreach (directed[i]) begin
      req.word  = directed[i];
      req.drain = (i == 10);
      req.rush  = 1'b0;
      word_backlog.push_back(req);
    end
    for (int k = 0; k < 350; k++) begin
      r = $urandom_range(0, 99);
      w = $urandom;
      if (r < 80) begin
        w = w & ~(PosMask | SetCountMask);
        w = w | ($urandom_range(0, 1) ? PosXyz : PosXyzrhw);
        w[11:8] = 4'($urandom_range(0, MaxSets));
      end else if (r < 90) begin
        w = (w & ~PosMask) | ($urandom_range(0, 1) ? PosXyz : PosXyzrhw);
        w[11:8] = 4'($urandom_range(MaxSets + 1, 15));
      end
      req.word  = w;
      req.drain = (k == 0) || ($urandom_range(0, 49) == 0);
      req.rush  = (k >= 120 && k < 160);
      word_backlog.push_back(req);
    end
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    while (word_backlog.size() != 0) @(posedge clk);
    while (layout_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (layout_due.size() != 0) begin
      $error("%0d descriptors never came", layout_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("vertex_format_layout_decoder_test: done, clean");
    end else begin
      $display("vertex_format_layout_decoder_test: done, errors");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("vertex_format_layout_decoder_test: done, errors");
    $finish;
  end

endmodule
